// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks; expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/mtp_pkg.sv
// ----------------------------------------------------------------------------
// mtp_pkg
// Types, codes and key tables shared by the metadata record parser.
// ----------------------------------------------------------------------------
package mtp_pkg;

  localparam int KEY_COUNT = 14;
  localparam logic [7:0] PK_BYTES = 8'd32;
  localparam logic [7:0] HASH_BYTES = 8'd32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

  localparam logic [3:0] KEY_VN = 4'd0;
  localparam logic [3:0] KEY_OP = 4'd1;
  localparam logic [3:0] KEY_QS = 4'd2;
  localparam logic [3:0] KEY_CO = 4'd3;
  localparam logic [3:0] KEY_CP = 4'd4;
  localparam logic [3:0] KEY_PK = 4'd5;
  localparam logic [3:0] KEY_NC = 4'd6;
  localparam logic [3:0] KEY_AL = 4'd7;
  localparam logic [3:0] KEY_BE = 4'd8;
  localparam logic [3:0] KEY_ST = 4'd9;
  localparam logic [3:0] KEY_VI = 4'd10;
  localparam logic [3:0] KEY_PD = 4'd11;
  localparam logic [3:0] KEY_VT = 4'd12;
  localparam logic [3:0] KEY_NO = 4'd13;

  localparam logic [15:0] KEY_NAMES [KEY_COUNT] = '{
    "VN", "OP", "QS", "CO", "CP", "PK", "NC",
    "AL", "BE", "ST", "VI", "PD", "VT", "NO"
  };

  // Bit 8 set: a length byte follows the key
  localparam logic [8:0] LEN_VAR = 9'h100;

  typedef enum logic [4:0] {
    PH_KEY1    = 5'b00001,
    PH_KEY2    = 5'b00010,
    PH_LEN     = 5'b00100,
    PH_VALUE   = 5'b01000,
    PH_DISCARD = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] key_code;
    logic [7:0] value_byte;
    logic       value_last;
    logic       cut_short;
  } res_t;

  typedef struct packed {
    logic push;
    res_t item;
  } q_wr_t;

  typedef struct packed {
    logic avail;
    res_t item;
  } q_rd_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] code;
  } key_hit_t;

  function automatic key_hit_t key_lookup(input logic [7:0] c1, input logic [7:0] c2);
    key_hit_t r;
    r = '0;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (KEY_NAMES[k] == {c1, c2}) begin
        r.hit = 1'b1;
        r.code = 4'(k);
      end
    end
    return r;
  endfunction

  function automatic logic [8:0] key_len(input logic [3:0] code);
    logic [8:0] r;
    case (code)
      KEY_VN, KEY_OP, KEY_QS: r = LEN_VAR;
      KEY_CO, KEY_CP, KEY_PK: r = {1'b0, PK_BYTES};
      KEY_NC: r = 9'd2;
      KEY_AL, KEY_BE, KEY_ST, KEY_NO: r = 9'd4;
      KEY_VI, KEY_PD: r = {1'b0, HASH_BYTES};
      KEY_VT: r = 9'd1;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: src/metadata_tlv_parser_top.sv
// ----------------------------------------------------------------------------
// metadata_tlv_parser_top
// Splits a metadata byte stream into keyed records, one value byte per item.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    data_byte, buffer_end
//   out      output     out_valid/out_stall  kind, key_code, value_byte,
//                                            value_last, cut_short
//
// One input item per cycle sustained while in_stall is low; a result passes
// through a queue slot, then the output register.
// in_stall rises only when the result queue of QUEUE_DEPTH entries is full.
// Synchronous reset returns the parser to the key phase and empties the queue.
// ----------------------------------------------------------------------------
module metadata_tlv_parser_top import mtp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       buffer_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [3:0] key_code,
  output logic [7:0] value_byte,
  output logic       value_last,
  output logic       cut_short
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  pop;

  mtp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .buffer_end (buffer_end),
    .q_full     (q_full),
    .q_wr       (q_wr)
  );

  mtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .q_full (q_full),
    .pop    (pop),
    .q_rd   (q_rd)
  );

  mtp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_rd       (q_rd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .key_code   (key_code),
    .value_byte (value_byte),
    .value_last (value_last),
    .cut_short  (cut_short)
  );

endmodule

// File: src/mtp_front.sv
// ----------------------------------------------------------------------------
// mtp_front
// Accepts buffer bytes, tracks the record phase and pushes result items.
// ----------------------------------------------------------------------------
module mtp_front import mtp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       buffer_end,
  input  logic       q_full,
  output q_wr_t      q_wr
);

  phase_t     phase, phase_next;
  logic [7:0] first_char, first_char_next;
  logic [3:0] cur_key, cur_key_next;
  logic [7:0] remain, remain_next;
  logic [7:0] remain_dec;
  logic       accept;
  logic       emit;
  res_t       res;
  key_hit_t   look;
  logic [8:0] len;

  assign in_stall = q_full;
  assign accept = in_valid & ~q_full;
  assign remain_dec = remain - 8'd1;

  always_comb begin
    phase_next = phase;
    first_char_next = first_char;
    cur_key_next = cur_key;
    remain_next = remain;
    emit = 1'b0;
    res = '0;
    look = key_lookup(first_char, data_byte);
    len = key_len(look.code);
    case (phase)
      PH_KEY2: begin
        if (!look.hit) begin
          phase_next = buffer_end ? PH_KEY1 : PH_DISCARD;
          emit = 1'b1;
          res.kind = KIND_UNKNOWN;
        end else begin
          cur_key_next = look.code;
          if (len[8]) begin
            phase_next = buffer_end ? PH_KEY1 : PH_LEN;
            emit = buffer_end;
            res.kind = KIND_TRUNC;
            res.key_code = look.code;
            res.cut_short = 1'b1;
          end else if (len[7:0] == 8'd0) begin
            phase_next = PH_KEY1;
            emit = 1'b1;
            res.kind = KIND_EMPTY;
            res.key_code = look.code;
            res.value_last = 1'b1;
          end else begin
            remain_next = len[7:0];
            phase_next = buffer_end ? PH_KEY1 : PH_VALUE;
            emit = buffer_end;
            res.kind = KIND_TRUNC;
            res.key_code = look.code;
            res.cut_short = 1'b1;
          end
        end
      end
      PH_LEN: begin
        remain_next = data_byte;
        if (data_byte == 8'd0) begin
          phase_next = PH_KEY1;
          emit = 1'b1;
          res.kind = KIND_EMPTY;
          res.key_code = cur_key;
          res.value_last = 1'b1;
        end else begin
          phase_next = buffer_end ? PH_KEY1 : PH_VALUE;
          emit = buffer_end;
          res.kind = KIND_TRUNC;
          res.key_code = cur_key;
          res.cut_short = 1'b1;
        end
      end
      PH_VALUE: begin
        remain_next = remain_dec;
        emit = 1'b1;
        res.kind = KIND_VALUE;
        res.key_code = cur_key;
        res.value_byte = data_byte;
        if (remain_dec == 8'd0) begin
          phase_next = PH_KEY1;
          res.value_last = 1'b1;
        end else if (buffer_end) begin
          phase_next = PH_KEY1;
          res.value_last = 1'b1;
          res.cut_short = 1'b1;
        end
      end
      PH_DISCARD: begin
        if (buffer_end) phase_next = PH_KEY1;
      end
      default: begin
        first_char_next = data_byte;
        phase_next = buffer_end ? PH_KEY1 : PH_KEY2;
        emit = buffer_end;
        res.kind = KIND_TRUNC;
        res.cut_short = 1'b1;
      end
    endcase
  end

  assign q_wr.push = accept & emit;
  assign q_wr.item = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_KEY1;
      first_char <= '0;
      cur_key <= '0;
      remain <= '0;
    end else if (accept) begin
      phase <= phase_next;
      first_char <= first_char_next;
      cur_key <= cur_key_next;
      remain <= remain_next;
    end
  end

endmodule

// File: src/mtp_queue.sv
// ----------------------------------------------------------------------------
// mtp_queue
// Short result queue between the parsing front and the output stage.
// ----------------------------------------------------------------------------
module mtp_queue import mtp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  q_wr_t q_wr,
  output logic  q_full,
  input  logic  pop,
  output q_rd_t q_rd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign q_full = (count == CW'(DEPTH));
  assign q_rd.avail = (count != '0);
  assign q_rd.item = slots[rd_ptr];
  assign do_push = q_wr.push & ~q_full;
  assign do_pop = pop & q_rd.avail;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= q_wr.item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/mtp_back.sv
// ----------------------------------------------------------------------------
// mtp_back
// Output register: drains the queue and holds each item under stall.
// ----------------------------------------------------------------------------
module mtp_back import mtp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_rd_t      q_rd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [3:0] key_code,
  output logic [7:0] value_byte,
  output logic       value_last,
  output logic       cut_short
);

  res_t hold;
  logic load;

  assign load = ~out_valid | ~out_stall;
  assign pop = load & q_rd.avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= q_rd.avail;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) hold <= q_rd.item;
  end

  assign kind = hold.kind;
  assign key_code = hold.key_code;
  assign value_byte = hold.value_byte;
  assign value_last = hold.value_last;
  assign cut_short = hold.cut_short;

endmodule

// File: src/mtp_checker.sv
// ----------------------------------------------------------------------------
// mtp_checker
// Port-level checks on result items of the metadata record parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtp_checker import mtp_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [3:0] key_code,
  input logic [7:0] value_byte,
  input logic       value_last,
  input logic       cut_short
);

  logic [15:0] out_bits;
  logic        cut_ok;
  logic        unknown_ok;

  assign out_bits = {kind, key_code, value_byte, value_last, cut_short};
  assign cut_ok = (kind == KIND_TRUNC && !value_last) || (kind == KIND_VALUE && value_last);
  assign unknown_ok = (key_code == 4'd0) && !value_last && !cut_short;

  `ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bits))

  `ASSERT_IMP(a_byte_zero, out_valid && kind != KIND_VALUE, value_byte == 8'd0)

  `ASSERT_IMP(a_empty_form, out_valid && kind == KIND_EMPTY, value_last && !cut_short)

  `ASSERT_IMP(a_cut_form, out_valid && cut_short, cut_ok)

  `ASSERT_IMP(a_unknown_form, out_valid && kind == KIND_UNKNOWN, unknown_ok)

endmodule

bind metadata_tlv_parser_top mtp_checker u_chk (.*);

// File: dv/metadata_tlv_parser_top_tb.sv
// ----------------------------------------------------------------------------
// metadata_tlv_parser_top_tb
// Feeds metadata buffers into the record parser and checks every result
// against an in-bench model of the key, length and value phases. Directed
// records and error cases come first, then random buffers under four
// idle/stall mixes on the input and output channels.
// ----------------------------------------------------------------------------
module metadata_tlv_parser_top_tb;
  import mtp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 310;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       buffer_end;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] kind;
  logic [3:0] key_code;
  logic [7:0] value_byte;
  logic       value_last;
  logic       cut_short;

  metadata_tlv_parser_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .buffer_end (buffer_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .key_code   (key_code),
    .value_byte (value_byte),
    .value_last (value_last),
    .cut_short  (cut_short)
  );

  // parser model state
  phase_t     parse_phase;
  logic [7:0] key_char1;
  logic [3:0] record_key;
  logic [7:0] value_left;

  res_t expected_records[$];
  res_t seen_record;
  res_t want_record;
  int   mismatches;
  int   items_sent;
  int   cycle_count;
  int   sender_idle_pct;
  int   receiver_stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("metadata_tlv_parser_top_tb: done, errors");
      $finish;
    end
  end

  function automatic int key_code_of(input logic [15:0] name);
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (KEY_NAMES[k] == name) return k;
    end
    return -1;
  endfunction

  // -1: a length byte follows the key
  function automatic int fixed_len(input logic [3:0] code);
    case (code)
      KEY_VN, KEY_OP, KEY_QS: return -1;
      KEY_CO, KEY_CP, KEY_PK: return int'(PK_BYTES);
      KEY_NC: return 2;
      KEY_AL, KEY_BE, KEY_ST, KEY_NO: return 4;
      KEY_VI, KEY_PD: return int'(HASH_BYTES);
      KEY_VT: return 1;
      default: return 0;
    endcase
  endfunction

  task automatic push_record(input logic [1:0] k, input logic [3:0] code,
                             input logic [7:0] b, input logic last, input logic cut);
    res_t r;
    r.kind = k;
    r.key_code = code;
    r.value_byte = b;
    r.value_last = last;
    r.cut_short = cut;
    expected_records = {expected_records, r};
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic fin);
    int code;
    int n;
    case (parse_phase)
      PH_KEY2: begin
        code = key_code_of({key_char1, b});
        if (code < 0) begin
          parse_phase = fin ? PH_KEY1 : PH_DISCARD;
          push_record(KIND_UNKNOWN, 4'd0, 8'd0, 1'b0, 1'b0);
        end else begin
          record_key = 4'(code);
          n = fixed_len(record_key);
          if (n < 0) begin
            parse_phase = PH_LEN;
            if (fin) begin
              parse_phase = PH_KEY1;
              push_record(KIND_TRUNC, record_key, 8'd0, 1'b0, 1'b1);
            end
          end else if (n == 0) begin
            parse_phase = PH_KEY1;
            push_record(KIND_EMPTY, record_key, 8'd0, 1'b1, 1'b0);
          end else begin
            value_left = 8'(n);
            parse_phase = PH_VALUE;
            if (fin) begin
              parse_phase = PH_KEY1;
              push_record(KIND_TRUNC, record_key, 8'd0, 1'b0, 1'b1);
            end
          end
        end
      end
      PH_LEN: begin
        value_left = b;
        if (b == 8'd0) begin
          parse_phase = PH_KEY1;
          push_record(KIND_EMPTY, record_key, 8'd0, 1'b1, 1'b0);
        end else if (fin) begin
          parse_phase = PH_KEY1;
          push_record(KIND_TRUNC, record_key, 8'd0, 1'b0, 1'b1);
        end else begin
          parse_phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        value_left = value_left - 8'd1;
        if (value_left == 8'd0) begin
          parse_phase = PH_KEY1;
          push_record(KIND_VALUE, record_key, b, 1'b1, 1'b0);
        end else if (fin) begin
          parse_phase = PH_KEY1;
          push_record(KIND_VALUE, record_key, b, 1'b1, 1'b1);
        end else begin
          push_record(KIND_VALUE, record_key, b, 1'b0, 1'b0);
        end
      end
      PH_DISCARD: begin
        if (fin) parse_phase = PH_KEY1;
      end
      default: begin
        key_char1 = b;
        if (fin) begin
          parse_phase = PH_KEY1;
          push_record(KIND_TRUNC, 4'd0, 8'd0, 1'b0, 1'b1);
        end else begin
          parse_phase = PH_KEY2;
        end
      end
    endcase
  endtask

  task automatic send_item(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    buffer_end <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, fin);
    items_sent++;
  endtask

  task automatic send_key(input logic [15:0] name, input logic fin);
    send_item(name[15:8], 1'b0);
    send_item(name[7:0], fin);
  endtask

  task automatic test_value_records();
    send_key("VT", 1'b0);
    send_item(8'hFF, 1'b0);
    send_key("VN", 1'b0);
    send_item(8'h00, 1'b0);
    send_key("OP", 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_cut_records();
    send_item("X", 1'b1);
    send_key("NC", 1'b1);
    send_key("QS", 1'b0);
    send_item(8'h05, 1'b1);
    send_key("AL", 1'b0);
    send_item(8'hA5, 1'b1);
  endtask

  task automatic test_unknown_keys();
    send_key("ZZ", 1'b1);
    send_key("QQ", 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'hAA, 1'b1);
  endtask

  task automatic test_random_buffers(input int idle_pct, input int stall_pct);
    logic [7:0]  stream[$];
    logic [15:0] name;
    int          first_item;
    int          sel;
    int          n;
    int          cut;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      stream.delete();
      repeat ($urandom_range(1, 4)) begin
        sel = $urandom_range(99);
        if (sel < 88) begin
          name = KEY_NAMES[$urandom_range(KEY_COUNT - 1)];
          stream = {stream, name[15:8]};
          stream = {stream, name[7:0]};
          n = fixed_len(4'(key_code_of(name)));
          if (n < 0) begin
            sel = $urandom_range(99);
            if (sel < 80) n = $urandom_range(0, 8);
            else if (sel < 95) n = $urandom_range(9, 40);
            else n = $urandom_range(128, 255);
            stream = {stream, 8'(n)};
          end
          repeat (n) stream = {stream, 8'($urandom_range(255))};
        end else if (sel < 94) begin
          do begin
            name = {KEY_NAMES[$urandom_range(KEY_COUNT - 1)][15:8],
                    8'($urandom_range(255))};
          end while (key_code_of(name) >= 0);
          stream = {stream, name[15:8]};
          stream = {stream, name[7:0]};
          repeat ($urandom_range(0, 3)) stream = {stream, 8'($urandom_range(255))};
        end else begin
          repeat ($urandom_range(1, 3)) stream = {stream, 8'($urandom_range(255))};
        end
      end
      if ($urandom_range(99) < 15 && stream.size() > 1) begin
        cut = $urandom_range(1, (stream.size() > 3) ? 3 : stream.size() - 1);
        repeat (cut) void'(stream.pop_back());
      end
      foreach (stream[i]) send_item(stream[i], i == stream.size() - 1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_record = {kind, key_code, value_byte, value_last, cut_short};
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d key %0d byte %02h last %0b cut %0b",
                   kind, key_code, value_byte, value_last, cut_short);
      end else begin
        want_record = expected_records.pop_front();
        if (seen_record.kind !== want_record.kind ||
            seen_record.key_code !== want_record.key_code ||
            seen_record.value_byte !== want_record.value_byte ||
            seen_record.value_last !== want_record.value_last ||
            seen_record.cut_short !== want_record.cut_short) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind %0d key %0d byte %02h last %0b cut %0b,",
                     want_record.kind, want_record.key_code, want_record.value_byte,
                     want_record.value_last, want_record.cut_short,
                     " got kind %0d key %0d byte %02h last %0b cut %0b",
                     kind, key_code, value_byte, value_last, cut_short);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'd0;
    buffer_end = 1'b0;
    out_stall = 1'b0;
    parse_phase = PH_KEY1;
    key_char1 = 8'd0;
    record_key = 4'd0;
    value_left = 8'd0;
    mismatches = 0;
    items_sent = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_value_records();
    test_cut_records();
    test_unknown_keys();
    test_random_buffers(0, 0);
    test_random_buffers(74, 0);
    test_random_buffers(0, 74);
    test_random_buffers(23, 23);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_records.size() == 0)
      $display("metadata_tlv_parser_top_tb: done, clean");
    else
      $display("metadata_tlv_parser_top_tb: done, errors");
    $finish;
  end

endmodule
